// ===== hw/rtl/matrix_vector_multiply_top_assert.svh =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply assertion macros
// Clocked assertion shorthands. The module that uses them must declare
// signals named clock and reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MVM_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MVM_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ===== hw/rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Shared widths, codes and types of the fixed-point matrix-vector multiplier.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam int MAX_COLS_DEFAULT = 1024;
   localparam int MAX_ROWS_DEFAULT = 65536;

   localparam int NUM_COLS_RESET = 1024;
   localparam int NUM_ROWS_RESET = 65536;

   localparam int COL_INDEX_W = 10;
   localparam int VALUE_W     = 32;
   localparam int ROW_INDEX_W = 16;
   localparam int ROW_VALUE_W = 64;

   localparam int NUM_COLS_W  = 11;
   localparam int NUM_ROWS_W  = 17;
   localparam int CSR_DATA_W  = NUM_ROWS_W;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_COLS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ROWS = 1'b1;

   localparam logic OP_LOAD_VECTOR = 1'b0;
   localparam logic OP_MATRIX      = 1'b1;

   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int RSP_COUNT_W    = $clog2(RSP_FIFO_DEPTH + 1);

   typedef struct packed {
      logic                   valid;
      logic                   end_of_row;
      logic                   last_row;
      logic [ROW_INDEX_W-1:0] row_index;
   } mac_ctrl_type;

   typedef struct packed {
      logic [ROW_INDEX_W-1:0]        row_index;
      logic signed [ROW_VALUE_W-1:0] row_value;
      logic                          last_row;
   } rsp_word_type;

endpackage

// ===== hw/rtl/mvm_channels.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply channels
// Valid/ready interfaces for the request and response streams.
// ----------------------------------------------------------------------------
interface mvm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                opcode;
   logic [mvm_pkg::COL_INDEX_W-1:0]     col_index;
   logic signed [mvm_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output opcode, output col_index, output value,
                   input ready);
   modport sink   (input valid, input opcode, input col_index, input value,
                   output ready);
endinterface

interface mvm_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [mvm_pkg::ROW_INDEX_W-1:0]        row_index;
   logic signed [mvm_pkg::ROW_VALUE_W-1:0] row_value;
   logic                                   last_row;

   modport source (output valid, output row_index, output row_value, output last_row,
                   input ready);
   modport sink   (input valid, input row_index, input row_value, input last_row,
                   output ready);
endinterface

// ===== hw/rtl/matrix_vector_multiply_top.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply top level
// A word is accepted every cycle while fewer than four results are outstanding; a row result
// is offered once its last matrix word has been multiplied, then added, and the sum is queued.
// Reset clears counters, accumulator and queue, sets num_cols 1024, num_rows 65536; x is kept.
// ----------------------------------------------------------------------------
`include "matrix_vector_multiply_top_assert.svh"

module matrix_vector_multiply_top #(
   parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEFAULT,
   parameter int MAX_ROWS = mvm_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   mvm_req_if.sink                            req_ch,
   mvm_rsp_if.source                          rsp_ch,
   input  logic                               csr_write_en,
   input  logic [mvm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mvm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   // Counter widths follow the store depth and the largest row count.
   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   // The register values after reset, already clamped to the parameters.
   localparam int COLS_RESET = (mvm_pkg::NUM_COLS_RESET > MAX_COLS) ?
                               MAX_COLS : mvm_pkg::NUM_COLS_RESET;
   localparam int ROWS_RESET = (mvm_pkg::NUM_ROWS_RESET > MAX_ROWS) ?
                               MAX_ROWS : mvm_pkg::NUM_ROWS_RESET;
   localparam logic [COL_W-1:0] LAST_COL_RESET = COL_W'(COLS_RESET - 1);
   localparam logic [ROW_W-1:0] LAST_ROW_RESET = ROW_W'(ROWS_RESET - 1);

   // Results that may be outstanding at once: the depth of the result queue.
   localparam logic [mvm_pkg::RSP_COUNT_W-1:0] OCC_MAX =
      mvm_pkg::RSP_COUNT_W'(mvm_pkg::RSP_FIFO_DEPTH);

   logic [COL_W-1:0]                     last_col_ff;
   logic [COL_W-1:0]                     last_col_in;
   logic [ROW_W-1:0]                     last_row_ff;
   logic [ROW_W-1:0]                     last_row_in;
   logic [COL_W-1:0]                     col_ctr_ff;
   logic [COL_W-1:0]                     col_ctr_in;
   logic [ROW_W-1:0]                     row_ctr_ff;
   logic [ROW_W-1:0]                     row_ctr_in;
   logic [mvm_pkg::RSP_COUNT_W-1:0]      occ_ff;
   logic [mvm_pkg::RSP_COUNT_W-1:0]      occ_in;
   mvm_pkg::mac_ctrl_type                s1_ctrl_ff;
   mvm_pkg::mac_ctrl_type                s1_ctrl_in;
   logic signed [mvm_pkg::VALUE_W-1:0]   s1_value_ff;
   logic [mvm_pkg::VALUE_W-1:0]          store_rd_data;
   logic [COL_W-1:0]                     load_addr;
   logic                                 req_accept;
   logic                                 mat_accept;
   logic                                 load_en;
   logic                                 end_of_row;
   logic                                 final_row;
   logic                                 row_done_accept;
   logic                                 rsp_pop;
   logic                                 push_valid;
   mvm_pkg::rsp_word_type                push_word;

   // ------------------------------------------------------------------------
   // Configuration. The registers are stored as the index of the last column
   // and the last row in use, clamped at write time: a zero count acts as one,
   // and a count above the parameter acts as the parameter. This keeps the
   // per-word end-of-row and final-row tests down to a single compare each.
   // ------------------------------------------------------------------------
   always_comb begin
      int cols_eff;
      int rows_eff;
      cols_eff = int'(csr_wdata[mvm_pkg::NUM_COLS_W-1:0]);
      rows_eff = int'(csr_wdata[mvm_pkg::NUM_ROWS_W-1:0]);
      if (cols_eff == 0) begin
         cols_eff = 1;
      end else if (cols_eff > MAX_COLS) begin
         cols_eff = MAX_COLS;
      end
      if (rows_eff == 0) begin
         rows_eff = 1;
      end else if (rows_eff > MAX_ROWS) begin
         rows_eff = MAX_ROWS;
      end
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      if (csr_write_en) begin
         case (csr_index)
            mvm_pkg::CSR_NUM_COLS: last_col_in = COL_W'(cols_eff - 1);
            mvm_pkg::CSR_NUM_ROWS: last_row_in = ROW_W'(rows_eff - 1);
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Request side. A word is taken whenever the response credit count shows
   // room, so a waiting result never holds up the request stream until four
   // results are outstanding. Vector loads write the store in the cycle they
   // are accepted; a matrix word issues its store read at the running column
   // in the same cycle. Because writes land at the accepting edge, a matrix
   // word that follows a load of the same entry already reads the new value.
   // ------------------------------------------------------------------------
   assign req_accept      = req_ch.valid && req_ch.ready;
   assign mat_accept      = req_accept && (req_ch.opcode == mvm_pkg::OP_MATRIX);
   assign load_en         = req_accept && (req_ch.opcode == mvm_pkg::OP_LOAD_VECTOR) &&
                            (int'(req_ch.col_index) < MAX_COLS);
   assign load_addr       = COL_W'(req_ch.col_index);
   assign end_of_row      = (col_ctr_ff >= last_col_ff);
   assign final_row       = (row_ctr_ff >= last_row_ff);
   assign row_done_accept = mat_accept && end_of_row;
   assign rsp_pop         = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready    = (occ_ff < OCC_MAX);

   // Column and row counters move at acceptance, so the flags that travel
   // down the pipe with each word are settled in order.
   always_comb begin
      col_ctr_in = col_ctr_ff;
      row_ctr_in = row_ctr_ff;
      if (mat_accept) begin
         if (end_of_row) begin
            col_ctr_in = '0;
            row_ctr_in = final_row ? '0 : row_ctr_ff + 1'b1;
         end else begin
            col_ctr_in = col_ctr_ff + 1'b1;
         end
      end
   end

   // The credit count covers results still in the pipe as well as those in
   // the queue, so the queue can never overflow.
   always_comb begin
      occ_in = occ_ff;
      if (row_done_accept && !rsp_pop) begin
         occ_in = occ_ff + 1'b1;
      end else if (!row_done_accept && rsp_pop) begin
         occ_in = occ_ff - 1'b1;
      end
   end

   always_comb begin
      s1_ctrl_in.valid      = mat_accept;
      s1_ctrl_in.end_of_row = end_of_row;
      s1_ctrl_in.last_row   = final_row;
      s1_ctrl_in.row_index  = mvm_pkg::ROW_INDEX_W'(row_ctr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= LAST_COL_RESET;
         last_row_ff <= LAST_ROW_RESET;
         col_ctr_ff  <= '0;
         row_ctr_ff  <= '0;
         occ_ff      <= '0;
         s1_ctrl_ff  <= '0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         col_ctr_ff  <= col_ctr_in;
         row_ctr_ff  <= row_ctr_in;
         occ_ff      <= occ_in;
         s1_ctrl_ff  <= s1_ctrl_in;
      end
   end

   // The matrix element is registered alongside the store read.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_value_ff <= req_ch.value;
      end
   end

   // ------------------------------------------------------------------------
   // Vector store, multiply-accumulate and response queue.
   // ------------------------------------------------------------------------
   mvm_vec_store #(
      .DEPTH   (MAX_COLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_ch.value),
      .rd_en   (mat_accept),
      .rd_addr (col_ctr_ff),
      .rd_data (store_rd_data)
   );

   mvm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .in_ctrl    (s1_ctrl_ff),
      .in_value   (s1_value_ff),
      .in_x       (store_rd_data),
      .push_valid (push_valid),
      .push_word  (push_word)
   );

   mvm_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .rsp_ch     (rsp_ch)
   );

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   `MVM_ASSERT_NOW(a_occ_bound, occ_ff <= OCC_MAX, "credit count exceeds queue depth")
   `MVM_ASSERT_NOW(a_rsp_has_credit, !rsp_ch.valid || (occ_ff != '0), "result with no credit")
   `MVM_ASSERT_NOW(a_col_in_store, int'(col_ctr_ff) < MAX_COLS, "column beyond store")
   `MVM_ASSERT_NEXT(a_row_restart, row_done_accept, col_ctr_ff == '0, "column not cleared")

endmodule

// ===== hw/rtl/mvm_vec_store.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply vector store
// Single-port-write, single-port-read memory holding x, registered read.
// ----------------------------------------------------------------------------
module mvm_vec_store #(
   parameter  int DEPTH  = mvm_pkg::MAX_COLS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [mvm_pkg::VALUE_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [mvm_pkg::VALUE_W-1:0]  rd_data
);
   logic [mvm_pkg::VALUE_W-1:0] mem_ff [DEPTH];
   logic [mvm_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/mvm_mac.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply MAC
// Registered 32x32 signed multiply followed by a saturating 64-bit accumulate.
// ----------------------------------------------------------------------------
module mvm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  mvm_pkg::mac_ctrl_type               in_ctrl,
   input  logic signed [mvm_pkg::VALUE_W-1:0]  in_value,
   input  logic [mvm_pkg::VALUE_W-1:0]         in_x,
   output logic                                push_valid,
   output mvm_pkg::rsp_word_type               push_word
);
   localparam logic signed [mvm_pkg::ROW_VALUE_W-1:0] SAT_MAX =
      {1'b0, {(mvm_pkg::ROW_VALUE_W-1){1'b1}}};
   localparam logic signed [mvm_pkg::ROW_VALUE_W-1:0] SAT_MIN =
      {1'b1, {(mvm_pkg::ROW_VALUE_W-1){1'b0}}};

   logic signed [mvm_pkg::VALUE_W-1:0]     x_signed;
   logic signed [mvm_pkg::ROW_VALUE_W-1:0] prod_in;
   logic signed [mvm_pkg::ROW_VALUE_W-1:0] prod_ff;
   mvm_pkg::mac_ctrl_type                  s2_ctrl_ff;
   logic signed [mvm_pkg::ROW_VALUE_W-1:0] acc_ff;
   logic signed [mvm_pkg::ROW_VALUE_W-1:0] acc_in;
   logic signed [mvm_pkg::ROW_VALUE_W-1:0] sum;

   // Each addition saturates on its own, so a later term can pull it back.
   function automatic logic signed [mvm_pkg::ROW_VALUE_W-1:0] sat_add(
      input logic signed [mvm_pkg::ROW_VALUE_W-1:0] a,
      input logic signed [mvm_pkg::ROW_VALUE_W-1:0] b
   );
      logic signed [mvm_pkg::ROW_VALUE_W-1:0] s;
      s = a + b;
      if ((a[mvm_pkg::ROW_VALUE_W-1] == b[mvm_pkg::ROW_VALUE_W-1]) &&
          (s[mvm_pkg::ROW_VALUE_W-1] != a[mvm_pkg::ROW_VALUE_W-1])) begin
         sat_add = a[mvm_pkg::ROW_VALUE_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         sat_add = s;
      end
   endfunction

   assign x_signed = $signed(in_x);
   assign prod_in  = in_value * x_signed;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctrl_ff <= '0;
         acc_ff     <= '0;
      end else begin
         s2_ctrl_ff <= in_ctrl;
         acc_ff     <= acc_in;
      end
   end

   always_comb begin
      sum    = sat_add(acc_ff, prod_ff);
      acc_in = acc_ff;
      if (s2_ctrl_ff.valid) begin
         acc_in = s2_ctrl_ff.end_of_row ? '0 : sum;
      end
      push_valid          = s2_ctrl_ff.valid && s2_ctrl_ff.end_of_row;
      push_word.row_index = s2_ctrl_ff.row_index;
      push_word.row_value = sum;
      push_word.last_row  = s2_ctrl_ff.last_row;
   end

endmodule

// ===== hw/rtl/mvm_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply response queue
// Small register queue between the accumulator and the response channel.
// ----------------------------------------------------------------------------
module mvm_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  mvm_pkg::rsp_word_type push_word,
   mvm_rsp_if.source             rsp_ch
);
   mvm_pkg::rsp_word_type               entry_ff [mvm_pkg::RSP_FIFO_DEPTH];
   logic [mvm_pkg::RSP_PTR_W-1:0]       wr_ptr_ff;
   logic [mvm_pkg::RSP_PTR_W-1:0]       wr_ptr_in;
   logic [mvm_pkg::RSP_PTR_W-1:0]       rd_ptr_ff;
   logic [mvm_pkg::RSP_PTR_W-1:0]       rd_ptr_in;
   logic [mvm_pkg::RSP_COUNT_W-1:0]     count_ff;
   logic [mvm_pkg::RSP_COUNT_W-1:0]     count_in;
   logic                                pop;
   mvm_pkg::rsp_word_type               head;

   // The caller never pushes into a full queue; its credit count sees to that.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      pop       = rsp_ch.valid && rsp_ch.ready;
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign head             = entry_ff[rd_ptr_ff];
   assign rsp_ch.valid     = (count_ff != '0);
   assign rsp_ch.row_index = head.row_index;
   assign rsp_ch.row_value = head.row_value;
   assign rsp_ch.last_row  = head.last_row;

endmodule
